### rtl/ridtt_pkg.sv
`timescale 1ns / 1ps
// ============================================================================
// ridtt_pkg
// Shared types and constants for the request ID translation table: beat
// payloads, table entry layout, controller states and commands.
// ============================================================================
package ridtt_pkg;

   // Table geometry. SLOTS must be a power of two: the slot is the low bits
   // of a serial and the generation is the remaining high bits.
   localparam int SLOTS       = 128;
   localparam int SLOT_W      = $clog2(SLOTS);
   localparam int SERIAL_W    = 16;
   localparam int GEN_W       = SERIAL_W - SLOT_W;
   localparam int TTL_W       = 16;
   localparam int TIME_W      = 32;

   // The serial counter runs modulo 65535, so its largest value is 65534.
   localparam logic [SERIAL_W-1:0] SERIAL_LAST = SERIAL_W'(65534);
   localparam logic [SERIAL_W-1:0] SERIAL_NONE = SERIAL_W'(65535);

   // Reset value of the entry lifetime register.
   localparam logic [TTL_W-1:0] TTL_RESET = TTL_W'(2);

   // Request modes.
   localparam logic MODE_ALLOC = 1'b0;
   localparam logic MODE_QUERY = 1'b1;

   // Request beat.
   typedef struct packed {
      logic                mode;
      logic [15:0]         origin_id;
      logic [31:0]         client_ip;
      logic [15:0]         client_port;
      logic [SERIAL_W-1:0] query_serial;
      logic [TIME_W-1:0]   now_seconds;
   } req_type;

   // Response beat.
   typedef struct packed {
      logic                ok;
      logic [SERIAL_W-1:0] serial_out;
      logic [15:0]         origin_out;
      logic [31:0]         ip_out;
      logic [15:0]         port_out;
   } rsp_type;

   // One stored translation.
   typedef struct packed {
      logic [TIME_W-1:0] expiry;
      logic [GEN_W-1:0]  generation;
      logic [15:0]       origin;
      logic [31:0]       ip;
      logic [15:0]       port;
   } entry_type;

   localparam int ENTRY_W = $bits(entry_type);

   // Controller states.
   typedef enum logic {
      CTL_IDLE,
      CTL_LOOKUP
   } ctl_state_type;

   // Commands from the controller to the datapath.
   typedef struct packed {
      logic load;    // capture the request and start the table read
      logic commit;  // decide, update the table and register the response
   } ctl_cmd_type;

endpackage

### rtl/ridtt_ram.sv
`timescale 1ns / 1ps
// ============================================================================
// ridtt_ram
// Generic simple dual-port RAM: one write port, one read port with a
// registered read.
// ============================================================================
module ridtt_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   // Write port.
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
   end

   // Registered read port.
   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

### rtl/ridtt_ctrl.sv
`timescale 1ns / 1ps
// ============================================================================
// ridtt_ctrl
// Controller for the translation table: accepts a request beat, sequences
// the table read and the decision cycle, and strobes the response beat.
// ============================================================================
module ridtt_ctrl
   import ridtt_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        start,
   output logic        busy,
   output logic        rsp_valid,
   output ctl_cmd_type cmd
);

   ctl_state_type state_ff;
   ctl_state_type state_in;
   logic          rsp_valid_ff;
   logic          rsp_valid_in;

   // State and strobe registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= CTL_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // Next state and commands.
   always_comb begin
      state_in     = state_ff;
      cmd          = '0;
      busy         = 1'b0;
      rsp_valid_in = 1'b0;
      case (state_ff)
         CTL_IDLE: begin
            if (start) begin
               cmd.load = 1'b1;
               state_in = CTL_LOOKUP;
            end
         end
         CTL_LOOKUP: begin
            busy         = 1'b1;
            cmd.commit   = 1'b1;
            rsp_valid_in = 1'b1;
            state_in     = CTL_IDLE;
         end
         default: begin
            state_in = CTL_IDLE;
         end
      endcase
   end

   assign rsp_valid = rsp_valid_ff;

`ifndef SYNTHESIS
   // An accepted request always moves into the decision cycle.
   a_load_to_lookup: assert property (@(posedge clock) disable iff (reset)
      cmd.load |=> (state_ff == CTL_LOOKUP) && busy)
      else $error("accepted request did not enter the decision cycle");

   // Every decision cycle is followed by exactly one response strobe.
   a_commit_strobes: assert property (@(posedge clock) disable iff (reset)
      cmd.commit |=> rsp_valid)
      else $error("decision cycle produced no response beat");

   // A response beat never lasts more than one cycle.
   a_strobe_single: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |=> !rsp_valid)
      else $error("response strobe held for two cycles");
`endif

endmodule

### rtl/ridtt_dp.sv
`timescale 1ns / 1ps
// ============================================================================
// ridtt_dp
// Datapath for the translation table: serial counter, lifetime register,
// valid bits, entry RAM, hit and expiry checks, and the response register.
// ============================================================================
module ridtt_dp
   import ridtt_pkg::*;
(
   input  logic             clock,
   input  logic             reset,
   input  ctl_cmd_type      cmd,
   input  req_type          req_data,
   input  logic             csr_wr_en,
   input  logic [TTL_W-1:0] csr_wr_data,
   output rsp_type          rsp_data
);

   logic [TTL_W-1:0]    ttl_ff;
   logic [SERIAL_W-1:0] serial_cnt_ff;
   logic [SERIAL_W-1:0] serial_next;
   logic [SERIAL_W-1:0] key_in;
   logic [SERIAL_W-1:0] key_ff;
   req_type             req_ff;
   logic [SLOTS-1:0]    valid_ff;
   rsp_type             rsp_ff;
   rsp_type             rsp_in;
   entry_type           entry_rd;
   entry_type           entry_wr;
   logic [SLOT_W-1:0]   slot;
   logic [GEN_W-1:0]    gen;
   logic                slot_valid;
   logic                slot_live;
   logic                alloc_ok;
   logic                query_ok;
   logic                ram_we;

   // Lifetime register; the user must write it only while the block is idle, the block does not enforce this.
   always_ff @(posedge clock) begin
      if (reset) begin
         ttl_ff <= TTL_RESET;
      end else if (csr_wr_en) begin
         ttl_ff <= csr_wr_data;
      end
   end

   // The counter advances modulo 65535 on every allocate, failed or not.
   assign serial_next = (serial_cnt_ff == SERIAL_LAST) ? '0 : serial_cnt_ff + SERIAL_W'(1);

   // The key is the new serial for an allocate and the given serial for a query.
   assign key_in = (req_data.mode == MODE_ALLOC) ? serial_next : req_data.query_serial;

   always_ff @(posedge clock) begin
      if (reset) begin
         serial_cnt_ff <= '0;
      end else if (cmd.load && (req_data.mode == MODE_ALLOC)) begin
         serial_cnt_ff <= serial_next;
      end
   end

   // Request capture.
   always_ff @(posedge clock) begin
      if (cmd.load) begin
         req_ff <= req_data;
         key_ff <= key_in;
      end
   end

   assign slot = key_ff[SLOT_W-1:0];
   assign gen  = key_ff[SERIAL_W-1:SLOT_W];

   // Hit and expiry checks against the entry read during the load cycle.
   assign slot_valid = valid_ff[slot];
   assign slot_live  = slot_valid && (entry_rd.expiry > req_ff.now_seconds);
   assign alloc_ok   = !slot_live;
   assign query_ok   = slot_valid && (entry_rd.generation == gen);

   // New entry for a successful allocate; the expiry wraps at 32 bits.
   always_comb begin
      entry_wr.expiry     = req_ff.now_seconds + TIME_W'(ttl_ff);
      entry_wr.generation = gen;
      entry_wr.origin     = req_ff.origin_id;
      entry_wr.ip         = req_ff.client_ip;
      entry_wr.port       = req_ff.client_port;
   end

   assign ram_we = cmd.commit && (req_ff.mode == MODE_ALLOC) && alloc_ok;

   ridtt_ram #(
      .WIDTH (ENTRY_W),
      .DEPTH (SLOTS)
   ) u_entry_ram (
      .clock   (clock),
      .wr_en   (ram_we),
      .wr_addr (slot),
      .wr_data (entry_wr),
      .rd_en   (cmd.load),
      .rd_addr (key_in[SLOT_W-1:0]),
      .rd_data (entry_rd)
   );

   // Valid bits: set by a successful allocate, cleared by a successful query.
   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
      end else if (cmd.commit) begin
         if (req_ff.mode == MODE_ALLOC) begin
            if (alloc_ok) begin
               valid_ff[slot] <= 1'b1;
            end
         end else if (query_ok) begin
            valid_ff[slot] <= 1'b0;
         end
      end
   end

   // Response; every field other than ok stays zero on a failure.
   always_comb begin
      rsp_in = '0;
      if (req_ff.mode == MODE_ALLOC) begin
         if (alloc_ok) begin
            rsp_in.ok         = 1'b1;
            rsp_in.serial_out = key_ff;
         end
      end else if (query_ok) begin
         rsp_in.ok         = 1'b1;
         rsp_in.origin_out = entry_rd.origin;
         rsp_in.ip_out     = entry_rd.ip;
         rsp_in.port_out   = entry_rd.port;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.commit) begin
         rsp_ff <= rsp_in;
      end
   end

   assign rsp_data = rsp_ff;

`ifndef SYNTHESIS
   // A successful allocate leaves its slot marked valid.
   a_alloc_sets_valid: assert property (@(posedge clock) disable iff (reset)
      cmd.commit && (req_ff.mode == MODE_ALLOC) && alloc_ok |=> valid_ff[slot])
      else $error("allocated slot not marked valid");

   // A successful query releases its slot.
   a_query_clears_valid: assert property (@(posedge clock) disable iff (reset)
      cmd.commit && (req_ff.mode == MODE_QUERY) && query_ok |=> !valid_ff[slot])
      else $error("released slot still marked valid");

   // The serial counter never reaches the value outside its modulus.
   a_serial_range: assert property (@(posedge clock) disable iff (reset)
      serial_cnt_ff != SERIAL_NONE)
      else $error("serial counter left its range");
`endif

endmodule

### rtl/request_id_translation_table_core.sv
`timescale 1ns / 1ps
// ============================================================================
// request_id_translation_table_core
// Relayed request ID translation table: hands out serials on allocate and
// maps a serial back to the original ID, client address and port on query.
// ============================================================================
//
//  Channel    Ports                            Handshake
//  ---------  -------------------------------  ------------------------------
//  request    start, busy, req_data            taken when start & !busy
//  response   rsp_valid, rsp_data              one-cycle strobe, no backpressure
//  config     csr_wr_en, csr_wr_data           written when csr_wr_en is high
//
//  The entry RAM is read on the accept edge and the decision and table update
//  happen in the following cycle, during which busy is high, so a new request
//  can be taken once the decision cycle is over. The response beat appears in the
//  cycle after the decision, alongside the next possible accept.
//  Reset clears the serial counter, the 128 valid bits and sets the lifetime
//  to 2 seconds; no clearing pass is needed. The receiver cannot stall.
//
module request_id_translation_table_core
   import ridtt_pkg::*;
(
   input  logic             clock,
   input  logic             reset,
   input  logic             start,
   output logic             busy,
   input  req_type          req_data,
   output logic             rsp_valid,
   output rsp_type          rsp_data,
   input  logic             csr_wr_en,
   input  logic [TTL_W-1:0] csr_wr_data
);

   ctl_cmd_type cmd;

   // Sequencing.
   ridtt_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .start     (start),
      .busy      (busy),
      .rsp_valid (rsp_valid),
      .cmd       (cmd)
   );

   // Table storage and checks.
   ridtt_dp u_dp (
      .clock       (clock),
      .reset       (reset),
      .cmd         (cmd),
      .req_data    (req_data),
      .csr_wr_en   (csr_wr_en),
      .csr_wr_data (csr_wr_data),
      .rsp_data    (rsp_data)
   );

endmodule

### tb/sv/testbench.sv
`timescale 1ns / 1ps
// ============================================================================
// Request ID translation table testbench
// Drives allocate and query beats into request_id_translation_table_core and
// compares every response beat with the output of a behavioral model that
// runs in step with the accepted requests. The run covers lookups right
// after reset, expiry wrap at 32 bits, busy slots, generation mismatches and
// queries at both ends of the serial range.
// ============================================================================
module testbench;
   import ridtt_pkg::*;

   logic             clock       = 1'b0;
   logic             reset       = 1'b1;
   logic             start       = 1'b0;
   logic             busy;
   req_type          req_data    = '0;
   logic             rsp_valid;
   rsp_type          rsp_data;
   logic             csr_wr_en   = 1'b0;
   logic [TTL_W-1:0] csr_wr_data = '0;

   request_id_translation_table_core dut (
      .clock       (clock),
      .reset       (reset),
      .start       (start),
      .busy        (busy),
      .req_data    (req_data),
      .rsp_valid   (rsp_valid),
      .rsp_data    (rsp_data),
      .csr_wr_en   (csr_wr_en),
      .csr_wr_data (csr_wr_data)
   );

   always #5 clock = ~clock;

   // Model of the table: lifetime register, serial counter and entries.
   logic [TTL_W-1:0]    lifetime_setting = TTL_RESET;
   logic [SERIAL_W-1:0] serial_count     = '0;
   logic                slot_live   [SLOTS];
   logic [TIME_W-1:0]   slot_expiry [SLOTS];
   logic [GEN_W-1:0]    slot_gen    [SLOTS];
   logic [15:0]         slot_origin [SLOTS];
   logic [31:0]         slot_ip     [SLOTS];
   logic [15:0]         slot_port   [SLOTS];

   // Responses predicted for accepted requests, oldest first.
   rsp_type             translations_due [$];
   // Serials believed to be held, and serials already released.
   logic [SERIAL_W-1:0] live_serials  [$];
   logic [SERIAL_W-1:0] spent_serials [$];

   bit sender_gaps = 1'b0;
   int error_count = 0;
   int allocs_granted = 0, allocs_refused = 0;
   int lookups_hit = 0, lookups_missed = 0, lifetime_writes = 0;

   initial begin
      for (int s = 0; s < SLOTS; s++) slot_live[s] = 1'b0;
   end

   // Work out the response to one request and update the model state.
   function automatic rsp_type predict_translation(input req_type r);
      rsp_type             res;
      logic [SERIAL_W-1:0] serial;
      logic [SLOT_W-1:0]   slot;
      logic [GEN_W-1:0]    gen;
      res = '0;
      if (r.mode == MODE_ALLOC) begin
         // The counter advances even when the slot turns out to be busy.
         serial = (serial_count == SERIAL_LAST) ? '0 : serial_count + 1'b1;
         serial_count = serial;
         slot = serial[SLOT_W-1:0];
         gen  = serial[SERIAL_W-1:SLOT_W];
         if (!(slot_live[slot] && slot_expiry[slot] > r.now_seconds)) begin
            slot_live[slot]   = 1'b1;
            slot_expiry[slot] = r.now_seconds + lifetime_setting;
            slot_gen[slot]    = gen;
            slot_origin[slot] = r.origin_id;
            slot_ip[slot]     = r.client_ip;
            slot_port[slot]   = r.client_port;
            res.ok            = 1'b1;
            res.serial_out    = serial;
         end
      end else begin
         // Expiry does not matter here: only validity and generation do.
         slot = r.query_serial[SLOT_W-1:0];
         gen  = r.query_serial[SERIAL_W-1:SLOT_W];
         if (slot_live[slot] && slot_gen[slot] == gen) begin
            res.ok         = 1'b1;
            res.origin_out = slot_origin[slot];
            res.ip_out     = slot_ip[slot];
            res.port_out   = slot_port[slot];
            slot_live[slot] = 1'b0;
         end
      end
      return res;
   endfunction

   function automatic req_type alloc_beat(input logic [15:0] origin, input logic [31:0] ip,
                                          input logic [15:0] port, input logic [31:0] now);
      req_type r;
      r.mode         = MODE_ALLOC;
      r.origin_id    = origin;
      r.client_ip    = ip;
      r.client_port  = port;
      r.query_serial = 16'($urandom);
      r.now_seconds  = now;
      return r;
   endfunction

   function automatic req_type query_beat(input logic [SERIAL_W-1:0] serial,
                                          input logic [31:0] now);
      req_type r;
      r.mode         = MODE_QUERY;
      r.origin_id    = 16'($urandom);
      r.client_ip    = $urandom;
      r.client_port  = 16'($urandom);
      r.query_serial = serial;
      r.now_seconds  = now;
      return r;
   endfunction

   task automatic flag_mismatch(input string what, input logic [31:0] got,
                                input logic [31:0] want);
      error_count++;
      // Keep the log short if the block is badly broken.
      if (error_count <= 30)
         $display("MISMATCH %s: got 0x%0h, expected 0x%0h at %0t", what, got, want, $realtime);
   endtask

   // Send one request beat; start is left high so back-to-back beats stay
   // back to back. The model is stepped at the accepting edge.
   task automatic send_request(input req_type item, output rsp_type predicted);
      if (sender_gaps && $urandom_range(0, 3) == 0) begin
         start <= 1'b0;
         repeat ($urandom_range(1, 10)) @(posedge clock);
      end
      req_data <= item;
      start    <= 1'b1;
      do @(posedge clock); while (busy !== 1'b0);
      predicted = predict_translation(item);
      translations_due.push_back(predicted);
      if (item.mode == MODE_ALLOC) begin
         if (predicted.ok) allocs_granted++; else allocs_refused++;
      end else begin
         if (predicted.ok) lookups_hit++; else lookups_missed++;
      end
   endtask

   // Stop sending and wait until every response has come back.
   task automatic settle_table();
      start <= 1'b0;
      while (translations_due.size() != 0) @(posedge clock);
      repeat (4) @(posedge clock);
   endtask

   task automatic load_entry_lifetime(input logic [TTL_W-1:0] value);
      settle_table();
      csr_wr_en   <= 1'b1;
      csr_wr_data <= value;
      @(posedge clock);
      csr_wr_en <= 1'b0;
      lifetime_setting = value;
      lifetime_writes++;
   endtask

   // Response checker: each beat is matched against the oldest prediction.
   always @(posedge clock) begin : check_responses
      rsp_type want;
      if (!reset && rsp_valid === 1'b1) begin
         if (translations_due.size() == 0) begin
            flag_mismatch("response beat with nothing outstanding", 32'd1, 32'd0);
         end else begin
            want = translations_due.pop_front();
            if (rsp_data.ok !== want.ok)
               flag_mismatch("ok", 32'(rsp_data.ok), 32'(want.ok));
            if (rsp_data.serial_out !== want.serial_out)
               flag_mismatch("serial_out", 32'(rsp_data.serial_out), 32'(want.serial_out));
            if (rsp_data.origin_out !== want.origin_out)
               flag_mismatch("origin_out", 32'(rsp_data.origin_out), 32'(want.origin_out));
            if (rsp_data.ip_out !== want.ip_out)
               flag_mismatch("ip_out", rsp_data.ip_out, want.ip_out);
            if (rsp_data.port_out !== want.port_out)
               flag_mismatch("port_out", 32'(rsp_data.port_out), 32'(want.port_out));
         end
      end
   end

   // Mixed traffic: allocates with random payloads, queries of held serials,
   // and stray queries (random, never-issued, released or wrong generation).
   task automatic run_mixed_traffic(input int count, input int alloc_pct,
                                    input logic [31:0] base, input bit gaps_ok);
      logic [31:0]         wall;
      logic [31:0]         now;
      logic [SERIAL_W-1:0] qs;
      req_type             item;
      rsp_type             got;
      int                  pick;
      int                  idx;
      bit                  held;
      wall = base;
      for (int i = 0; i < count; i++) begin
         if (i % 32 == 0) sender_gaps = gaps_ok && ($urandom_range(0, 1) == 1);
         wall = wall + $urandom_range(0, 3);
         now  = ($urandom_range(0, 19) == 0) ? $urandom : wall;
         pick = $urandom_range(0, 99);
         held = 1'b0;
         if (pick < alloc_pct) begin
            item = alloc_beat(16'($urandom), $urandom, 16'($urandom), now);
         end else if (pick < alloc_pct + (100 - alloc_pct) * 3 / 4 && live_serials.size() != 0) begin
            idx  = $urandom_range(0, live_serials.size() - 1);
            qs   = live_serials[idx];
            live_serials.delete(idx);
            held = 1'b1;
            item = query_beat(qs, now);
         end else begin
            case ($urandom_range(0, 3))
               0: qs = 16'($urandom);
               1: qs = SERIAL_NONE;
               2: qs = (spent_serials.size() != 0) ?
                       spent_serials[$urandom_range(0, spent_serials.size() - 1)] :
                       16'($urandom);
               default: begin
                  // Same slot, different generation.
                  qs = (live_serials.size() != 0) ?
                       live_serials[$urandom_range(0, live_serials.size() - 1)] : '0;
                  qs = qs ^ (16'd1 << $urandom_range(SLOT_W, SERIAL_W - 1));
               end
            endcase
            item = query_beat(qs, now);
         end
         send_request(item, got);
         if (item.mode == MODE_ALLOC && got.ok) begin
            live_serials.push_back(got.serial_out);
            if (live_serials.size() > 256) void'(live_serials.pop_front());
         end
         if (held && got.ok) begin
            spent_serials.push_back(qs);
            if (spent_serials.size() > 64) void'(spent_serials.pop_front());
         end
      end
   endtask

   // Lookups with the reset lifetime: payload extremes, wrong generation,
   // double release, serial 65535, never-issued serials and expired entries.
   task automatic test_basic_lookup();
      rsp_type unused;
      send_request(alloc_beat(16'h0000, 32'h0000_0000, 16'h0000, 32'd1000), unused);
      send_request(alloc_beat(16'hFFFF, 32'hFFFF_FFFF, 16'hFFFF, 32'd1000), unused);
      send_request(alloc_beat(16'hA5C3, 32'h5A3C_96E1, 16'h3C5A, 32'd1001), unused);
      send_request(query_beat(16'd2 + 16'(SLOTS), 32'd1001), unused);
      send_request(query_beat(16'd2, 32'd1001), unused);
      send_request(query_beat(16'd2, 32'd1001), unused);
      send_request(query_beat(16'd1, 32'd1002), unused);
      send_request(query_beat(SERIAL_NONE, 32'd1002), unused);
      send_request(query_beat(16'd0, 32'd1002), unused);
      // Long past its expiry, the entry can still be looked up.
      send_request(query_beat(16'd3, 32'hFFFF_FFFF), unused);
      send_request(query_beat(16'd4, 32'd0), unused);
      // Slot 4 was never written; this one is free at any time.
      send_request(alloc_beat(16'h1234, 32'hC0A8_0001, 16'd53, 32'hFFFF_FFFF), unused);
      send_request(query_beat(16'd4, 32'd0), unused);
   endtask

   // Longest lifetime around the 32-bit time wrap: expiries wrap and slots
   // come round again while still held.
   task automatic test_expiry_wrap_traffic();
      load_entry_lifetime(16'hFFFF);
      run_mixed_traffic(210, 65, 32'hFFFF_FF00, 1'b1);
   endtask

   task automatic test_zero_lifetime_traffic();
      load_entry_lifetime(16'h0000);
      run_mixed_traffic(60, 55, 32'd0, 1'b1);
   endtask

   task automatic test_random_lifetime_traffic();
      load_entry_lifetime(16'($urandom_range(1, 65534)));
      run_mixed_traffic(80, 60, $urandom, 1'b1);
   endtask

   // Short lifetime with time held at its maximum so that the expiry wraps
   // and nothing counts as still live, then queries of serials at both ends
   // of the serial range, then mixed traffic with a lifetime of 300.
   task automatic test_serial_extremes();
      rsp_type unused;
      load_entry_lifetime(16'd1);
      sender_gaps = 1'b0;
      send_request(alloc_beat(16'h0101, 32'h0A00_0001, 16'd1000, 32'hFFFF_FFFF), unused);
      send_request(alloc_beat(16'h0202, 32'h0A00_0002, 16'd2000, 32'hFFFF_FFFF), unused);
      send_request(alloc_beat(16'h0303, 32'h0A00_0003, 16'd3000, 32'hFFFF_FFFF), unused);
      send_request(alloc_beat(16'h0404, 32'h0A00_0004, 16'd4000, 32'hFFFF_FFFF), unused);
      send_request(query_beat(SERIAL_LAST, 32'd5), unused);
      send_request(query_beat(16'd0, 32'd5), unused);
      send_request(query_beat(16'd0, 32'd5), unused);
      send_request(query_beat(SERIAL_NONE, 32'd5), unused);
      send_request(query_beat(16'd1, 32'd5), unused);
      send_request(query_beat(SERIAL_LAST - 16'd1, 32'd5), unused);
      live_serials.delete();
      load_entry_lifetime(16'd300);
      run_mixed_traffic(80, 60, 32'd100, 1'b1);
   endtask

   // Closing stretch at full rate with the reset lifetime value.
   task automatic test_steady_traffic();
      load_entry_lifetime(TTL_RESET);
      run_mixed_traffic(100, 55, 32'd50_000, 1'b0);
   endtask

   initial begin
      repeat (11) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      test_basic_lookup();
      test_expiry_wrap_traffic();
      test_zero_lifetime_traffic();
      test_random_lifetime_traffic();
      test_serial_extremes();
      test_steady_traffic();
      settle_table();
      repeat (8) @(posedge clock);
      $display("Covered %0d allocates (%0d granted, %0d refused as busy) and %0d queries",
               allocs_granted + allocs_refused, allocs_granted, allocs_refused,
               lookups_hit + lookups_missed);
      $display("(%0d hits, %0d misses) over %0d lifetime settings",
               lookups_hit, lookups_missed, lifetime_writes + 1);
      if (error_count == 0) begin
         $display("DONE: 0 errors");
      end else begin
         $display("DONE: errors detected");
      end
      $finish;
   end

   // Watchdog: far beyond the slowest correct run.
   initial begin
      #20_000_000;
      $display("DONE: errors detected");
      $finish;
   end

endmodule
